[hw/rtl/spr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stream pattern replace block.
// No dependencies.
package spr_pkg;

	localparam int SPR_MAX_PATTERN = 8;
	localparam int SPR_REPL_MAX    = 8;
	localparam int SPR_CFG_IDX_W   = 2;
	localparam int SPR_CFG_DATA_W  = 64;

	localparam logic [SPR_CFG_IDX_W-1:0] REG_PATTERN_BYTES = 2'd0;
	localparam logic [SPR_CFG_IDX_W-1:0] REG_PATTERN_LEN   = 2'd1;
	localparam logic [SPR_CFG_IDX_W-1:0] REG_REPLACE_BYTES = 2'd2;
	localparam logic [SPR_CFG_IDX_W-1:0] REG_REPLACE_LEN   = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in;
	} spr_in_word_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        out_last;
		logic [31:0] length_so_far;
	} spr_out_word_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_REPL
	} spr_state_t;

	typedef struct packed {
		logic append;
		logic clear_held;
		logic release_byte;
		logic repl_emit;
		logic marker;
		logic end_buf;
	} spr_cmd_t;

	typedef struct packed {
		logic match;
		logic release_need;
		logic held_nz;
		logic last;
		logic emitted;
		logic rlen_zero;
		logic repl_last;
		logic out_free;
	} spr_status_t;

endpackage

[hw/rtl/spr_dp.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, held byte line, counters, output register.
// Depends on spr_pkg.
module spr_dp #(
	parameter int MAX_PATTERN = spr_pkg::SPR_MAX_PATTERN
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [spr_pkg::SPR_CFG_IDX_W-1:0]    cfg_index,
	input  logic [spr_pkg::SPR_CFG_DATA_W-1:0]   cfg_data,
	input  spr_pkg::spr_in_word_t                in_data,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output spr_pkg::spr_out_word_t               out_data,
	input  spr_pkg::spr_cmd_t                    cmd,
	output spr_pkg::spr_status_t                 status
);
	import spr_pkg::*;

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [63:0]      pattern_q;
	logic [3:0]       pattern_len_q;
	logic [63:0]      replace_q;
	logic [3:0]       replace_len_q;
	logic [7:0]       held_q [MAX_PATTERN];
	logic [CNT_W-1:0] count_q;
	logic [31:0]      emitted_q;
	logic [2:0]       idx_q;
	logic             last_q;
	logic             step_emit_q;
	logic             out_valid_q;
	spr_out_word_t    out_q;

	logic [CNT_W-1:0] plen;
	logic [3:0]       rlen;
	logic             prefix;
	logic [31:0]      next_len;
	logic [7:0]       repl_byte;
	logic             emit;

	always_comb begin
		if (pattern_len_q == 4'd0)
			plen = CNT_W'(1);
		else if (pattern_len_q > 4'(MAX_PATTERN))
			plen = CNT_W'(MAX_PATTERN);
		else
			plen = pattern_len_q[CNT_W-1:0];
		rlen = (replace_len_q > 4'(SPR_REPL_MAX)) ? 4'(SPR_REPL_MAX) : replace_len_q;
	end

	always_comb begin
		prefix = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((CNT_W'(i) < count_q) && (held_q[i] != pattern_q[8*i +: 8]))
				prefix = 1'b0;
		end
	end

	assign next_len  = (emitted_q == '1) ? emitted_q : emitted_q + 32'd1;
	assign repl_byte = replace_q[{idx_q, 3'b000} +: 8];
	assign emit      = cmd.release_byte | cmd.repl_emit | cmd.marker;

	always_comb begin
		status.match        = (count_q == plen) && prefix;
		status.release_need = (count_q != '0) && ((count_q >= plen) || !prefix);
		status.held_nz      = (count_q != '0);
		status.last         = last_q;
		status.emitted      = step_emit_q;
		status.rlen_zero    = (rlen == 4'd0);
		status.repl_last    = ({1'b0, idx_q} == (rlen - 4'd1));
		status.out_free     = !out_valid_q || !out_stall;
	end

	// held bytes carry no reset; only entries below the count are read
	always_ff @(posedge clk) begin
		if (cmd.append)
			held_q[count_q[IDX_W-1:0]] <= in_data.data_byte;
		else if (cmd.release_byte) begin
			for (int i = 0; i < MAX_PATTERN - 1; i++)
				held_q[i] <= held_q[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= '0;
			pattern_len_q <= 4'd1;
			replace_q     <= '0;
			replace_len_q <= '0;
			count_q       <= '0;
			emitted_q     <= '0;
			idx_q         <= '0;
			last_q        <= 1'b0;
			step_emit_q   <= 1'b0;
		end else begin
			if (cmd.append) begin
				count_q     <= count_q + CNT_W'(1);
				last_q      <= in_data.last_in;
				idx_q       <= '0;
				step_emit_q <= 1'b0;
			end
			if (cmd.clear_held)
				count_q <= '0;
			if (cmd.release_byte)
				count_q <= count_q - CNT_W'(1);
			if (cmd.repl_emit)
				idx_q <= idx_q + 3'd1;
			if (emit && !cmd.end_buf)
				step_emit_q <= 1'b1;
			if (cmd.release_byte || cmd.repl_emit)
				emitted_q <= next_len;
			if (cmd.end_buf) begin
				emitted_q   <= '0;
				step_emit_q <= 1'b0;
				last_q      <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN_BYTES: begin
						pattern_q <= cfg_data;
						count_q   <= '0;
					end
					REG_PATTERN_LEN: begin
						pattern_len_q <= cfg_data[3:0];
						count_q       <= '0;
					end
					REG_REPLACE_BYTES: replace_q     <= cfg_data;
					REG_REPLACE_LEN:   replace_len_q <= cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.release_byte) begin
			out_q.out_byte      <= held_q[0];
			out_q.byte_valid    <= 1'b1;
			out_q.out_last      <= last_q && (count_q == CNT_W'(1));
			out_q.length_so_far <= next_len;
		end else if (cmd.repl_emit) begin
			out_q.out_byte      <= repl_byte;
			out_q.byte_valid    <= 1'b1;
			out_q.out_last      <= last_q && status.repl_last;
			out_q.length_so_far <= next_len;
		end else if (cmd.marker) begin
			out_q.out_byte      <= 8'd0;
			out_q.byte_valid    <= 1'b0;
			out_q.out_last      <= 1'b1;
			out_q.length_so_far <= emitted_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hw/rtl/spr_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences accept, match check, release, replacement and end marker.
// Depends on spr_pkg.
module spr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  spr_pkg::spr_status_t status,
	output spr_pkg::spr_cmd_t    cmd
);
	import spr_pkg::*;

	spr_state_t state_q;
	spr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.append = 1'b1;
					state_d    = S_EVAL;
				end
			end
			S_EVAL: begin
				if (status.match) begin
					cmd.clear_held = 1'b1;
					state_d        = S_REPL;
				end else if (status.held_nz && (status.release_need || status.last)) begin
					if (status.out_free)
						cmd.release_byte = 1'b1;
				end else if (status.last && !status.emitted) begin
					if (status.out_free) begin
						cmd.marker  = 1'b1;
						cmd.end_buf = 1'b1;
						state_d     = S_IDLE;
					end
				end else begin
					cmd.end_buf = status.last;
					state_d     = S_IDLE;
				end
			end
			S_REPL: begin
				if (status.rlen_zero)
					state_d = S_EVAL;
				else if (status.out_free) begin
					cmd.repl_emit = 1'b1;
					if (status.repl_last)
						state_d = S_EVAL;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[hw/rtl/stream_pattern_replace.sv]
`timescale 1ns / 1ps
// Top level of the stream pattern replace block.
// Depends on spr_pkg, spr_ctrl and spr_dp.
//
// Byte stream find-and-replace: each leftmost, non-overlapping occurrence of
// the pattern (1 to MAX_PATTERN bytes) is replaced by 0 to 8 replacement bytes;
// other bytes pass in order. Bytes that may still start a match are held and
// released once they cannot. A word with last_in set flushes the held bytes and
// ends the buffer; its final output word has out_last set, and if that input
// gave no byte an empty end marker (byte_valid low) carries the total length.
// Each input word is accepted in the idle state and then evaluated; the
// evaluate state releases the output bytes it frees one at a time and returns
// to idle, and no new word is taken before then. A match moves to the replace
// state, which emits the replacement bytes in order and returns to evaluate.
// A stall on the single output register holds each release or emit. Write
// configuration only while the block idles.
module stream_pattern_replace #(
	parameter int MAX_PATTERN = spr_pkg::SPR_MAX_PATTERN
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [spr_pkg::SPR_CFG_IDX_W-1:0]  cfg_index,
	input  logic [spr_pkg::SPR_CFG_DATA_W-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  spr_pkg::spr_in_word_t              in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output spr_pkg::spr_out_word_t             out_data
);
	import spr_pkg::*;

	spr_cmd_t    cmd;
	spr_status_t status;

	spr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	spr_dp #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

[hw/rtl/spr_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for stream_pattern_replace, bound to the top level.
// Depends on spr_pkg.
module spr_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input spr_pkg::spr_out_word_t out_data
);
	import spr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output word changed");

	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |-> out_data.out_last && out_data.out_byte == 8'd0)
		else $error("empty marker malformed");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.byte_valid |-> out_data.length_so_far != 32'd0)
		else $error("data word with zero length");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on consecutive cycles");

endmodule

bind stream_pattern_replace spr_checker u_spr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
